FILE: hw/rtl/cti_pkg.sv
// cti_pkg: shared types and constants of the calibration table interpolator
// no dependencies; used by cti_front, cti_back, the top and cti_checker

package cti_pkg;

	localparam int MAX_POINTS_DEF  = 16;
	localparam int FREQ_W          = 32;
	localparam int VAL_W           = 8;
	localparam int INDEX_W         = 4;
	localparam int COUNT_W         = 5;
	localparam int PROD_W          = FREQ_W + VAL_W;
	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int RES_QUEUE_DEPTH = 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// classified request handed from the front to the back
	typedef struct packed {
		logic               is_query;
		logic               write_ok;
		logic [INDEX_W-1:0] index;
		logic [FREQ_W-1:0]  frequency;
		logic [VAL_W-1:0]   value;
	} item_t;

endpackage

FILE: hw/rtl/cti_fifo.sv
// cti_fifo: small register-based first-in first-out queue
// generic storage, no package dependency

module cti_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cti_front.sv
// cti_front: accepts requests, classifies them and queues them for the engine
// depends on cti_pkg and cti_fifo

module cti_front #(
	parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        command,
	input  logic [cti_pkg::INDEX_W-1:0] entry_index,
	input  logic [cti_pkg::FREQ_W-1:0]  frequency,
	input  logic [cti_pkg::VAL_W-1:0]   entry_value,
	output cti_pkg::item_t              item,
	output logic                        item_valid,
	input  logic                        item_take
);

	cti_pkg::item_t                   in_item;
	logic [$bits(cti_pkg::item_t)-1:0] q_data;
	logic                             q_empty;

	// writes past the table are flagged here (write_ok clear), they never reach the engine's memory
	always_comb begin
		in_item.is_query  = (command == cti_pkg::CMD_QUERY);
		in_item.write_ok  = (command == cti_pkg::CMD_WRITE) &&
			(32'(entry_index) < 32'(MAX_POINTS));
		in_item.index     = entry_index;
		in_item.frequency = frequency;
		in_item.value     = entry_value;
	end

	cti_fifo #(
		.WIDTH ($bits(cti_pkg::item_t)),
		.DEPTH (cti_pkg::CMD_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (in_item),
		.full      (full),
		.pop       (item_take),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	assign item       = cti_pkg::item_t'(q_data);
	assign item_valid = !q_empty;

endmodule

FILE: hw/rtl/cti_back.sv
// cti_back: table memory, sequential search and shift-subtract interpolation engine
// depends on cti_pkg

module cti_back #(
	parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cti_pkg::COUNT_W-1:0] point_count,
	input  cti_pkg::item_t              item,
	input  logic                        item_valid,
	output logic                        item_take,
	output logic                        res_push,
	output logic [cti_pkg::VAL_W-1:0]   res_data,
	input  logic                        res_full
);

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int FW     = cti_pkg::FREQ_W;
	localparam int VW     = cti_pkg::VAL_W;
	localparam int PW     = cti_pkg::PROD_W;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_FIRST  = 8'b0000_0010,
		ST_LAST   = 8'b0000_0100,
		ST_SEARCH = 8'b0000_1000,
		ST_MUL    = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_FIN    = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t           state_q;
	state_t           state_d;

	logic [FW+VW-1:0] tbl_mem [MAX_POINTS];
	logic [FW+VW-1:0] rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             tbl_we;
	logic [IDX_W-1:0] wr_addr;
	logic [FW-1:0]    rd_f;
	logic [VW-1:0]    rd_v;

	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] k_q;
	logic [FW-1:0]    target_q;
	logic [FW+VW-1:0] lo_q;
	logic [FW-1:0]    lo_f;
	logic [VW-1:0]    lo_v;
	logic [FW-1:0]    span_q;
	logic [FW-1:0]    off_q;
	logic [VW-1:0]    a_q;
	logic [VW-1:0]    diff_q;
	logic             rise_q;
	logic [PW-1:0]    prod;
	logic [PW-1:0]    rem_q;
	logic [2:0]       bit_q;
	logic [VW-1:0]    quo_q;
	logic [VW-1:0]    res_q;
	logic [PW:0]      trial;
	logic             search_stop;

	assign rd_f = rd_q[FW+VW-1:VW];
	assign rd_v = rd_q[VW-1:0];
	assign lo_f = lo_q[FW+VW-1:VW];
	assign lo_v = lo_q[VW-1:0];

	// last entry in use: zero acts as one point, large counts saturate
	always_comb begin
		if (point_count == '0) begin
			last_idx = '0;
		end else if (32'(point_count) > 32'(MAX_POINTS)) begin
			last_idx = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = IDX_W'(point_count - cti_pkg::COUNT_W'(1));
		end
	end

	assign item_take   = (state_q == ST_IDLE) && item_valid;
	assign tbl_we      = item_take && !item.is_query && item.write_ok;
	assign wr_addr     = IDX_W'(item.index);
	assign search_stop = (k_q == last_q) || (rd_f >= target_q);
	assign prod        = off_q * diff_q;
	assign trial       = {1'b0, rem_q} - {1'b0, PW'(span_q) << bit_q};
	assign res_push    = (state_q == ST_OUT) && !res_full;
	assign res_data    = res_q;

	always_comb begin
		case (state_q)
			ST_FIRST:  rd_addr = last_q;
			ST_LAST:   rd_addr = IDX_W'(1);
			ST_SEARCH: rd_addr = k_q + IDX_W'(1);
			default:   rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[wr_addr] <= {item.frequency, item.value};
		end
		rd_q <= tbl_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (item_take && item.is_query) state_d = ST_FIRST;
			ST_FIRST:  state_d = (target_q <= rd_f) ? ST_OUT : ST_LAST;
			ST_LAST:   state_d = (target_q >= rd_f) ? ST_OUT : ST_SEARCH;
			ST_SEARCH: if (search_stop) state_d = ST_MUL;
			ST_MUL:    state_d = ST_DIV;
			ST_DIV:    if (bit_q == 3'd0) state_d = ST_FIN;
			ST_FIN:    state_d = ST_OUT;
			ST_OUT:    if (!res_full) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_take) begin
					target_q <= item.frequency;
					last_q   <= last_idx;
				end
			end
			ST_FIRST: begin
				lo_q  <= rd_q;
				res_q <= rd_v;
			end
			ST_LAST: begin
				res_q <= rd_v;
				k_q   <= IDX_W'(1);
			end
			ST_SEARCH: begin
				if (search_stop) begin
					span_q <= rd_f - lo_f;
					off_q  <= target_q - lo_f;
					a_q    <= lo_v;
					rise_q <= (lo_v < rd_v);
					diff_q <= (lo_v < rd_v) ? rd_v - lo_v : lo_v - rd_v;
				end else begin
					lo_q <= rd_q;
					k_q  <= k_q + IDX_W'(1);
				end
			end
			ST_MUL: begin
				rem_q <= prod;
				bit_q <= 3'd7;
				quo_q <= '0;
			end
			ST_DIV: begin
				// quotient stays below 256 since offset never exceeds span
				if (!trial[PW]) begin
					rem_q        <= trial[PW-1:0];
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 3'd1;
			end
			ST_FIN: begin
				res_q <= rise_q ? a_q + quo_q : a_q - quo_q;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/calibration_table_interpolator_top.sv
// calibration_table_interpolator_top: piecewise linear calibration lookup
// a query clamps at the first or last point, otherwise it interpolates between the bracketing pair;
// an in-range write is stored as the engine takes it, a clamped query reads only the end points, and an
// interpolating query scans with one table read per cycle, then runs an 8-step shift-subtract divide
// arst_n clears queues and engine state and sets point_count to 1; the table is not cleared
// depends on cti_pkg, cti_fifo, cti_front, cti_back

module calibration_table_interpolator_top #(
	parameter int MAX_POINTS = cti_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        push,
	output logic                        full,
	input  logic                        command,
	input  logic [cti_pkg::INDEX_W-1:0] entry_index,
	input  logic [cti_pkg::FREQ_W-1:0]  frequency,
	input  logic [cti_pkg::VAL_W-1:0]   entry_value,
	// result side
	output logic                        empty,
	input  logic                        pop,
	output logic [cti_pkg::VAL_W-1:0]   interpolated_value,
	// point_count register
	input  logic                        cfg_we,
	input  logic [cti_pkg::COUNT_W-1:0] cfg_wdata
);

	logic [cti_pkg::COUNT_W-1:0] point_count_q;

	// front to back request queue
	cti_pkg::item_t              link_item;
	logic                        link_valid;
	logic                        link_take;

	// back to result queue
	logic                        res_push;
	logic [cti_pkg::VAL_W-1:0]   res_data;
	logic                        res_full;

	// point count; the user writes it only while the block is idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= cti_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// front: classify and queue every request, writes and queries in order
	cti_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.entry_index (entry_index),
		.frequency   (frequency),
		.entry_value (entry_value),
		.item        (link_item),
		.item_valid  (link_valid),
		.item_take   (link_take)
	);

	// back: table storage, scan for the bracketing points, multiply and divide
	cti_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (point_count_q),
		.item        (link_item),
		.item_valid  (link_valid),
		.item_take   (link_take),
		.res_push    (res_push),
		.res_data    (res_data),
		.res_full    (res_full)
	);

	// result queue decouples the engine from a stalled consumer
	cti_fifo #(
		.WIDTH (cti_pkg::VAL_W),
		.DEPTH (cti_pkg::RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.full      (res_full),
		.pop       (pop),
		.pop_data  (interpolated_value),
		.empty     (empty)
	);

endmodule

FILE: hw/rtl/cti_checker.sv
// cti_checker: port-level assertions for the calibration table interpolator
// depends on cti_pkg; bound to calibration_table_interpolator_top

module cti_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic                        command,
	input logic                        empty,
	input logic                        pop,
	input logic [cti_pkg::VAL_W-1:0]   interpolated_value
);

	logic [7:0] pending_q;
	logic       query_in;
	logic       result_out;

	assign query_in   = push && !full && (command == cti_pkg::CMD_QUERY);
	assign result_out = pop && !empty;

	// queries accepted whose result has not yet been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({query_in, result_out})
				2'b10:   pending_q <= pending_q + 8'd1;
				2'b01:   pending_q <= pending_q - 8'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	// during reset both queues read as drained
	a_reset_drained: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not drained during reset");

	// a result only shows up for a query still owed one
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pending_q != 8'd0))
		else $error("result without an outstanding query");

	// a waiting result holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(interpolated_value)))
		else $error("waiting result changed");

endmodule

bind calibration_table_interpolator_top cti_checker u_cti_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.push               (push),
	.full               (full),
	.command            (command),
	.empty              (empty),
	.pop                (pop),
	.interpolated_value (interpolated_value)
);
